>>> design/x87p_pkg.sv
// package with field widths, rounding mode codes and item structs for the x87 extended packer
`timescale 1ns / 1ps

package x87p_pkg;

    localparam int EXP_IN_W   = 16;
    localparam int EXP_OUT_W  = 15;
    localparam int SIG_W      = 64;
    localparam int SHIFT_W    = 7;
    localparam int SHIFT_MAX  = SIG_W + 1;
    localparam int S_DATA_W   = 88;
    localparam int M_DATA_W   = 80;

    typedef enum logic [1:0] {
        RND_NEAREST = 2'd0,
        RND_DOWN    = 2'd1,
        RND_UP      = 2'd2,
        RND_CHOP    = 2'd3
    } rnd_mode_t;

    typedef struct packed {
        logic                        is_zero;
        logic                        sign;
        logic signed [EXP_IN_W-1:0]  exponent;
        logic [SIG_W-1:0]            significand;
    } unpacked_t;

    typedef struct packed {
        logic                        sign;
        logic [EXP_OUT_W-1:0]        exponent;
        logic [SIG_W-1:0]            significand;
    } ext_word_t;

endpackage

>>> design/x87p_pack.sv
// combinational packing of one unpacked value into x87 extended fields with denormal rounding
`timescale 1ns / 1ps

module x87p_pack (
    input  x87p_pkg::unpacked_t  value,
    input  x87p_pkg::rnd_mode_t  rounding_mode,
    output x87p_pkg::ext_word_t  word
);

    localparam int WIDE_W = x87p_pkg::SIG_W + x87p_pkg::SHIFT_MAX;

    logic                              exp_positive;
    logic signed [x87p_pkg::EXP_IN_W:0] shift_full;
    logic [x87p_pkg::SHIFT_W-1:0]      shift;
    logic [WIDE_W-1:0]                 wide;
    logic [x87p_pkg::SIG_W-1:0]        q;
    logic                              half;
    logic                              sticky;
    logic                              round_up;
    logic [x87p_pkg::SIG_W-1:0]        rounded;

    assign exp_positive = !value.exponent[x87p_pkg::EXP_IN_W-1] && (|value.exponent);

    // shift is one minus the exponent, clamped where every bit lands in sticky
    assign shift_full = (x87p_pkg::EXP_IN_W+1)'(1)
                      - {value.exponent[x87p_pkg::EXP_IN_W-1], value.exponent};
    assign shift = (shift_full > (x87p_pkg::EXP_IN_W+1)'(x87p_pkg::SHIFT_MAX))
                 ? x87p_pkg::SHIFT_W'(x87p_pkg::SHIFT_MAX)
                 : shift_full[x87p_pkg::SHIFT_W-1:0];

    assign wide   = {value.significand, {x87p_pkg::SHIFT_MAX{1'b0}}} >> shift;
    assign q      = wide[WIDE_W-1 -: x87p_pkg::SIG_W];
    assign half   = wide[x87p_pkg::SIG_W];
    assign sticky = |wide[x87p_pkg::SIG_W-1:0];

    always_comb begin
        unique case (rounding_mode)
            x87p_pkg::RND_NEAREST: round_up = half && (sticky || q[0]);
            x87p_pkg::RND_DOWN:    round_up = (half || sticky) && value.sign;
            x87p_pkg::RND_UP:      round_up = (half || sticky) && !value.sign;
            x87p_pkg::RND_CHOP:    round_up = 1'b0;
            default:               round_up = 1'b0;
        endcase
    end

    assign rounded = q + x87p_pkg::SIG_W'(round_up);

    always_comb begin
        word.sign = value.sign;
        if (exp_positive) begin
            word.exponent    = value.exponent[x87p_pkg::EXP_OUT_W-1:0];
            word.significand = value.significand;
        end else begin
            word.exponent    = '0;
            word.significand = value.is_zero ? '0 : rounded;
        end
    end

endmodule

>>> design/x87_extended_pack_with_denormal_round_top.sv
// top level of the x87 extended packer: request registers around the pack and round logic
//
//  channel   dir  fields
//  s_        in   tuser: is_zero; tdata: sign_in, exponent_in, significand_in
//  m_        out  tdata: sign_out, exponent_out, significand_out
//  cfg_      in   wdata: rounding_mode
//
// a request passes the input register, then the result register; one request per cycle sustained while m_tready is high
// the barrel shift and increment sit between the input and result registers
// a stalled result holds in its register while the input register still fills
// aresetn clears both valid flags and sets rounding mode to nearest-even
`timescale 1ns / 1ps

module x87_extended_pack_with_denormal_round_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [1:0]                     cfg_wdata,   // rounding_mode
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [x87p_pkg::S_DATA_W-1:0]  s_tdata,     // sign_in, exponent_in, significand_in
    input  logic                           s_tuser,     // is_zero
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [x87p_pkg::M_DATA_W-1:0]  m_tdata      // sign_out, exponent_out, significand_out
);

    x87p_pkg::rnd_mode_t  mode_reg, mode_next;
    logic                 in_valid_reg, in_valid_next;
    x87p_pkg::unpacked_t  in_data_reg, in_data_next;
    logic                 out_valid_reg, out_valid_next;
    x87p_pkg::ext_word_t  out_data_reg, out_data_next;

    x87p_pkg::unpacked_t  s_value;
    x87p_pkg::ext_word_t  packed_word;
    logic                 out_ready;
    logic                 in_ready;

    assign s_value.is_zero     = s_tuser;
    assign s_value.sign        = s_tdata[0];
    assign s_value.exponent    = s_tdata[x87p_pkg::EXP_IN_W:1];
    assign s_value.significand = s_tdata[x87p_pkg::EXP_IN_W+x87p_pkg::SIG_W:x87p_pkg::EXP_IN_W+1];

    assign out_ready = !out_valid_reg || m_tready;
    assign in_ready  = !in_valid_reg || out_ready;
    assign s_tready  = in_ready;

    x87p_pack u_pack (
        .value         (in_data_reg),
        .rounding_mode (mode_reg),
        .word          (packed_word)
    );

    always_comb begin
        mode_next      = cfg_wen ? x87p_pkg::rnd_mode_t'(cfg_wdata) : mode_reg;
        in_valid_next  = in_ready ? s_tvalid : in_valid_reg;
        in_data_next   = (in_ready && s_tvalid) ? s_value : in_data_reg;
        out_valid_next = out_ready ? in_valid_reg : out_valid_reg;
        out_data_next  = (out_ready && in_valid_reg) ? packed_word : out_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= x87p_pkg::RND_NEAREST;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.significand, out_data_reg.exponent, out_data_reg.sign};

endmodule

>>> sim/tb_x87_extended_pack_with_denormal_round_top.sv
// testbench for the x87 extended packer: random and edge requests checked against a built-in model
`timescale 1ns / 1ps

module tb_x87_extended_pack_with_denormal_round_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 256;
    localparam int LONG_HOLD    = 60;

    class pack_board;
        x87p_pkg::rnd_mode_t mode;
        x87p_pkg::ext_word_t expected_q[$];
        int                  mismatches;

        function new();
            mode = x87p_pkg::RND_NEAREST;
            mismatches = 0;
        endfunction

        function x87p_pkg::ext_word_t pack_extended(x87p_pkg::unpacked_t v);
            x87p_pkg::ext_word_t r;
            int                  e;
            int                  shift;
            logic [63:0]         q;
            logic                half;
            logic                sticky;
            logic                bump;
            e = int'($signed(v.exponent));
            r.sign = v.sign;
            if (e > 0) begin
                r.exponent = v.exponent[x87p_pkg::EXP_OUT_W-1:0];
                r.significand = v.significand;
            end else begin
                r.exponent = '0;
                if (v.is_zero) begin
                    r.significand = '0;
                end else begin
                    shift = 1 - e;
                    if (shift >= 65) begin
                        q = '0;
                        half = 1'b0;
                        sticky = |v.significand;
                    end else if (shift == 64) begin
                        q = '0;
                        half = v.significand[63];
                        sticky = |v.significand[62:0];
                    end else begin
                        q = v.significand >> shift;
                        half = v.significand[shift-1];
                        sticky = (shift >= 2) ?
                            ((v.significand & ((64'd1 << (shift - 1)) - 64'd1)) != 64'd0) : 1'b0;
                    end
                    case (mode)
                        x87p_pkg::RND_NEAREST: bump = half && (sticky || q[0]);
                        x87p_pkg::RND_DOWN:    bump = (half || sticky) && v.sign;
                        x87p_pkg::RND_UP:      bump = (half || sticky) && !v.sign;
                        default:               bump = 1'b0;
                    endcase
                    r.significand = q + {63'd0, bump};
                end
            end
            return r;
        endfunction

        function void note(x87p_pkg::unpacked_t v);
            expected_q.push_back(pack_extended(v));
        endfunction

        function void check(x87p_pkg::ext_word_t got);
            x87p_pkg::ext_word_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: sign %0b exp %h sig %h",
                             got.sign, got.exponent, got.significand);
            end else begin
                want = expected_q.pop_front();
                if (want.sign !== got.sign || want.exponent !== got.exponent ||
                    want.significand !== got.significand) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected sign %0b exp %h sig %h, ",
                                  "got sign %0b exp %h sig %h"},
                                 want.sign, want.exponent, want.significand,
                                 got.sign, got.exponent, got.significand);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wen;
    logic [1:0]                    cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [x87p_pkg::S_DATA_W-1:0] s_tdata;
    logic                          s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [x87p_pkg::M_DATA_W-1:0] m_tdata;

    pack_board board;
    bit        long_hold;
    int        cycle_count;

    x87_extended_pack_with_denormal_round_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    function automatic x87p_pkg::unpacked_t make_operand(bit zero, bit neg, int e,
                                                         logic [63:0] sig);
        x87p_pkg::unpacked_t v;
        v.is_zero = zero;
        v.sign = neg;
        v.exponent = 16'(e);
        v.significand = sig;
        return v;
    endfunction

    function automatic x87p_pkg::unpacked_t random_operand();
        x87p_pkg::unpacked_t v;
        int                  k;
        logic [63:0]         raw;
        raw = {$urandom, $urandom};
        v.is_zero = ($urandom_range(0, 7) == 0);
        v.sign = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v.exponent = 16'(-int'($urandom_range(0, 70)));
            4:          v.exponent = 16'($urandom) | 16'h8000;
            5:          v.exponent = 16'($urandom_range(0, 1));
            6:          v.exponent = 16'($urandom);
            default:    v.exponent = 16'($urandom_range(1, 32767));
        endcase
        k = $urandom_range(0, 63);
        case ($urandom_range(0, 7))
            0:       v.significand = '1;
            1:       v.significand = 64'd1 << k;
            2:       v.significand = (64'd1 << k) - 64'd1;
            3:       v.significand = raw >> k;
            4:       v.significand = '0;
            5: begin
                // exact halfway point at the shift position
                k = $urandom_range(1, 63);
                v.exponent = 16'(1 - k);
                v.significand = (raw << k) | (64'd1 << (k - 1));
            end
            default: v.significand = raw;
        endcase
        return v;
    endfunction

    task automatic send_request(x87p_pkg::unpacked_t v, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= v.is_zero;
        s_tdata  <= {7'd0, v.significand, v.exponent, v.sign};
        do @(posedge aclk); while (!s_tready);
        board.note(v);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.pending() > 0);
    endtask

    task automatic set_rounding(x87p_pkg::rnd_mode_t m);
        drain_results();
        repeat (3) @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        board.mode = m;
    endtask

    task automatic run_directed();
        x87p_pkg::unpacked_t edge_q[$];
        edge_q.push_back(make_operand(1'b0, 1'b1, 32767, '1));
        edge_q.push_back(make_operand(1'b1, 1'b0, 1, 64'h8000_0000_0000_0000));
        edge_q.push_back(make_operand(1'b1, 1'b1, 1, 64'h1234_5678_9abc_def0));
        edge_q.push_back(make_operand(1'b0, 1'b0, 0, '1));
        edge_q.push_back(make_operand(1'b0, 1'b1, 0, '1));
        edge_q.push_back(make_operand(1'b1, 1'b0, 0, 64'hdead_beef_0000_0001));
        edge_q.push_back(make_operand(1'b1, 1'b1, -32768, '1));
        edge_q.push_back(make_operand(1'b0, 1'b0, -32768, '1));
        edge_q.push_back(make_operand(1'b0, 1'b1, -32768, 64'd1));
        edge_q.push_back(make_operand(1'b0, 1'b0, -63, 64'h8000_0000_0000_0000));
        edge_q.push_back(make_operand(1'b0, 1'b0, -63, 64'hc000_0000_0000_0000));
        edge_q.push_back(make_operand(1'b0, 1'b1, -63, 64'h7fff_ffff_ffff_ffff));
        edge_q.push_back(make_operand(1'b0, 1'b0, -64, 64'd1));
        edge_q.push_back(make_operand(1'b0, 1'b0, -62, 64'hffff_ffff_ffff_ffff));
        edge_q.push_back(make_operand(1'b0, 1'b0, 0, 64'd1));
        edge_q.push_back(make_operand(1'b0, 1'b0, 0, 64'd3));
        edge_q.push_back(make_operand(1'b0, 1'b0, -1, 64'd6));
        edge_q.push_back(make_operand(1'b0, 1'b1, -1, 64'd5));
        edge_q.push_back(make_operand(1'b0, 1'b0, -5, '0));
        edge_q.push_back(make_operand(1'b0, 1'b0, 32767, '0));
        edge_q.push_back(make_operand(1'b1, 1'b1, 0, '0));
        foreach (edge_q[i])
            send_request(edge_q[i], $urandom_range(0, 7));
    endtask

    task automatic run_random(int count, bit with_hold, bit with_pause);
        int gap;
        for (int i = 0; i < count; i++) begin
            if (with_pause && i == count / 2)
                drain_results();
            if (with_hold && i == 20)
                long_hold = 1'b1;
            if (with_hold && i >= 20 && i < 80)
                gap = 0;
            else if ((i % 128) < 24)
                gap = 0;
            else
                gap = $urandom_range(0, 7);
            send_request(random_operand(), gap);
        end
    endtask

    // result side
    initial begin
        int                  stall;
        int                  seen;
        x87p_pkg::ext_word_t got;
        seen = 0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = ((seen % 96) < 20) ? 0 : $urandom_range(0, 7);
            if (long_hold) begin
                stall = LONG_HOLD;
                long_hold = 1'b0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.sign        = m_tdata[0];
            got.exponent    = m_tdata[15:1];
            got.significand = m_tdata[79:16];
            board.check(got);
            seen++;
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        board = new();
        long_hold = 1'b0;
        aresetn   <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_wdata <= x87p_pkg::RND_NEAREST;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        set_rounding(x87p_pkg::RND_CHOP);
        run_random(PHASE_ITEMS, 1'b0, 1'b0);
        set_rounding(x87p_pkg::RND_DOWN);
        run_random(PHASE_ITEMS, 1'b1, 1'b0);
        set_rounding(x87p_pkg::RND_UP);
        run_random(PHASE_ITEMS, 1'b0, 1'b1);
        set_rounding(x87p_pkg::RND_NEAREST);
        run_random(PHASE_ITEMS, 1'b0, 1'b0);
        drain_results();
        repeat (10) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
design/x87p_pkg.sv
design/x87p_pack.sv
design/x87_extended_pack_with_denormal_round_top.sv
sim/tb_x87_extended_pack_with_denormal_round_top.sv
